// File: hw/rtl/hsv_pkg.sv
// Shared types and constants for the HSV to RGB color converter.
// Used by every stage module and by the top level; depends on nothing.
package hsv_pkg;

    // Hue limits after clamping: zero maps to one, 360 and above to 359.
    localparam logic [8:0] HUE_MIN   = 9'd1;
    localparam logic [8:0] HUE_LIMIT = 9'd360;
    localparam logic [8:0] HUE_MAX   = 9'd359;
    localparam logic [6:0] PCT_LIMIT = 7'd100;
    localparam logic [5:0] SECTOR_DEG = 6'd60;
    localparam logic [14:0] CHAN_SCALE = 15'd255;
    localparam logic [12:0] SECTOR_FULL = 13'd6000;

    // Sector codes, one per sixty degrees of hue.
    localparam logic [2:0] SEC_RED     = 3'd0;
    localparam logic [2:0] SEC_YELLOW  = 3'd1;
    localparam logic [2:0] SEC_GREEN   = 3'd2;
    localparam logic [2:0] SEC_CYAN    = 3'd3;
    localparam logic [2:0] SEC_BLUE    = 3'd4;
    localparam logic [2:0] SEC_MAGENTA = 3'd5;

    // Constant divisors and their truncated reciprocals.
    localparam int unsigned DIV_SHIFT = 28;
    localparam int unsigned PROD_W    = 37;
    localparam logic [19:0] DIV_V = 20'd100;
    localparam logic [19:0] DIV_P = 20'd10000;
    localparam logic [19:0] DIV_Q = 20'd600000;
    localparam logic [21:0] RECIP_V = 22'((64'd1 << DIV_SHIFT) / 64'd100);
    localparam logic [21:0] RECIP_P = 22'((64'd1 << DIV_SHIFT) / 64'd10000);
    localparam logic [21:0] RECIP_Q = 22'((64'd1 << DIV_SHIFT) / 64'd600000);

    typedef struct packed {
        logic [2:0] sector;
        logic [5:0] frac;
        logic [6:0] sat;
        logic [6:0] val;
    } hsv_sect_t;

    typedef struct packed {
        logic [2:0]  sector;
        logic [14:0] vk;
        logic [6:0]  diff_p;
        logic [12:0] diff_q;
        logic [12:0] diff_t;
    } hsv_diff_t;

    typedef struct packed {
        logic [2:0]  sector;
        logic [14:0] num_v;
        logic [21:0] num_p;
        logic [27:0] num_q;
        logic [27:0] num_t;
    } hsv_num_t;

    typedef struct packed {
        logic [2:0]  sector;
        logic [14:0] num_v;
        logic [21:0] num_p;
        logic [27:0] num_q;
        logic [27:0] num_t;
        logic [7:0]  est_v;
        logic [7:0]  est_p;
        logic [7:0]  est_q;
        logic [7:0]  est_t;
    } hsv_est_t;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } hsv_rgb_t;

endpackage

// File: hw/rtl/hsv_sector.sv
// First pipeline stage: input saturation, hue clamping, sector and fraction.
// Depends on hsv_pkg.
module hsv_sector (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [8:0]        in_hue,
    input  logic [6:0]        in_sat,
    input  logic [6:0]        in_bri,
    output logic              out_valid,
    input  logic              out_ready,
    output hsv_pkg::hsv_sect_t out_data
);

    logic [8:0]         hue_clip;
    logic [8:0]         hue_base;
    hsv_pkg::hsv_sect_t data_next;
    hsv_pkg::hsv_sect_t data_reg;
    logic               valid_reg;

    always_comb begin
        if (in_hue >= hsv_pkg::HUE_LIMIT) begin
            hue_clip = hsv_pkg::HUE_MAX;
        end else if (in_hue == 9'd0) begin
            hue_clip = hsv_pkg::HUE_MIN;
        end else begin
            hue_clip = in_hue;
        end

        if (hue_clip < 9'd60) begin
            data_next.sector = hsv_pkg::SEC_RED;
            hue_base = 9'd0;
        end else if (hue_clip < 9'd120) begin
            data_next.sector = hsv_pkg::SEC_YELLOW;
            hue_base = 9'd60;
        end else if (hue_clip < 9'd180) begin
            data_next.sector = hsv_pkg::SEC_GREEN;
            hue_base = 9'd120;
        end else if (hue_clip < 9'd240) begin
            data_next.sector = hsv_pkg::SEC_CYAN;
            hue_base = 9'd180;
        end else if (hue_clip < 9'd300) begin
            data_next.sector = hsv_pkg::SEC_BLUE;
            hue_base = 9'd240;
        end else begin
            data_next.sector = hsv_pkg::SEC_MAGENTA;
            hue_base = 9'd300;
        end

        data_next.frac = 6'(hue_clip - hue_base);
        data_next.sat  = (in_sat > hsv_pkg::PCT_LIMIT) ? hsv_pkg::PCT_LIMIT : in_sat;
        data_next.val  = (in_bri > hsv_pkg::PCT_LIMIT) ? hsv_pkg::PCT_LIMIT : in_bri;
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

// File: hw/rtl/hsv_mul.sv
// Second and third pipeline stages: the sector weights and the scaled
// numerators of v, p, q and t. Depends on hsv_pkg.
module hsv_mul (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  hsv_pkg::hsv_sect_t in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output hsv_pkg::hsv_num_t  out_data
);

    logic [12:0]        frac_sat;
    logic [12:0]        rest_sat;
    hsv_pkg::hsv_diff_t diff_next;
    hsv_pkg::hsv_diff_t diff_reg;
    logic               diff_valid_reg;
    logic               diff_ready;
    hsv_pkg::hsv_num_t  num_next;
    hsv_pkg::hsv_num_t  num_reg;
    logic               num_valid_reg;
    logic               num_ready;

    // Weights 100 - s, 6000 - f*s and 6000 - (60 - f)*s never go negative.
    always_comb begin
        frac_sat = 13'(in_data.frac) * 13'(in_data.sat);
        rest_sat = 13'(hsv_pkg::SECTOR_DEG - in_data.frac) * 13'(in_data.sat);
        diff_next.sector = in_data.sector;
        diff_next.vk     = 15'(in_data.val) * hsv_pkg::CHAN_SCALE;
        diff_next.diff_p = hsv_pkg::PCT_LIMIT - in_data.sat;
        diff_next.diff_q = hsv_pkg::SECTOR_FULL - frac_sat;
        diff_next.diff_t = hsv_pkg::SECTOR_FULL - rest_sat;
    end

    always_comb begin
        num_next.sector = diff_reg.sector;
        num_next.num_v  = diff_reg.vk;
        num_next.num_p  = 22'(diff_reg.vk) * 22'(diff_reg.diff_p);
        num_next.num_q  = 28'(diff_reg.vk) * 28'(diff_reg.diff_q);
        num_next.num_t  = 28'(diff_reg.vk) * 28'(diff_reg.diff_t);
    end

    assign num_ready  = !num_valid_reg || out_ready;
    assign diff_ready = !diff_valid_reg || num_ready;
    assign in_ready   = diff_ready;
    assign out_valid  = num_valid_reg;
    assign out_data   = num_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            diff_valid_reg <= 1'b0;
            num_valid_reg  <= 1'b0;
        end else begin
            if (diff_ready) begin
                diff_valid_reg <= in_valid;
            end
            if (num_ready) begin
                num_valid_reg <= diff_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (diff_ready && in_valid) begin
            diff_reg <= diff_next;
        end
        if (num_ready && diff_valid_reg) begin
            num_reg <= num_next;
        end
    end

endmodule

// File: hw/rtl/hsv_div.sv
// Fourth and fifth pipeline stages: division by constants through reciprocal
// multiplication, a one-step correction, and the sector channel select.
// Depends on hsv_pkg.
module hsv_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  hsv_pkg::hsv_num_t in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output hsv_pkg::hsv_rgb_t out_data
);

    // The truncated reciprocal leaves the estimate at most one below the
    // true quotient, so one compare of the remainder fixes it.
    function automatic logic [7:0] fix_quot(input logic [27:0] num,
                                            input logic [7:0]  est,
                                            input logic [19:0] dvs);
        logic [27:0] rem;
        rem = num - 28'(est) * 28'(dvs);
        if (rem >= 28'(dvs)) begin
            return est + 8'd1;
        end
        return est;
    endfunction

    logic [hsv_pkg::PROD_W-1:0] prod_v;
    logic [hsv_pkg::PROD_W-1:0] prod_p;
    logic [hsv_pkg::PROD_W-1:0] prod_q;
    logic [hsv_pkg::PROD_W-1:0] prod_t;
    hsv_pkg::hsv_est_t          est_next;
    hsv_pkg::hsv_est_t          est_reg;
    logic                       est_valid_reg;
    logic                       est_ready;
    logic [7:0]                 chan_v;
    logic [7:0]                 chan_p;
    logic [7:0]                 chan_q;
    logic [7:0]                 chan_t;
    hsv_pkg::hsv_rgb_t          rgb_next;
    hsv_pkg::hsv_rgb_t          rgb_reg;
    logic                       rgb_valid_reg;
    logic                       rgb_ready;

    always_comb begin
        prod_v = hsv_pkg::PROD_W'(in_data.num_v) * hsv_pkg::PROD_W'(hsv_pkg::RECIP_V);
        prod_p = hsv_pkg::PROD_W'(in_data.num_p) * hsv_pkg::PROD_W'(hsv_pkg::RECIP_P);
        prod_q = hsv_pkg::PROD_W'(in_data.num_q) * hsv_pkg::PROD_W'(hsv_pkg::RECIP_Q);
        prod_t = hsv_pkg::PROD_W'(in_data.num_t) * hsv_pkg::PROD_W'(hsv_pkg::RECIP_Q);
        est_next.sector = in_data.sector;
        est_next.num_v  = in_data.num_v;
        est_next.num_p  = in_data.num_p;
        est_next.num_q  = in_data.num_q;
        est_next.num_t  = in_data.num_t;
        est_next.est_v  = prod_v[hsv_pkg::DIV_SHIFT +: 8];
        est_next.est_p  = prod_p[hsv_pkg::DIV_SHIFT +: 8];
        est_next.est_q  = prod_q[hsv_pkg::DIV_SHIFT +: 8];
        est_next.est_t  = prod_t[hsv_pkg::DIV_SHIFT +: 8];
    end

    always_comb begin
        chan_v = fix_quot(28'(est_reg.num_v), est_reg.est_v, hsv_pkg::DIV_V);
        chan_p = fix_quot(28'(est_reg.num_p), est_reg.est_p, hsv_pkg::DIV_P);
        chan_q = fix_quot(est_reg.num_q, est_reg.est_q, hsv_pkg::DIV_Q);
        chan_t = fix_quot(est_reg.num_t, est_reg.est_t, hsv_pkg::DIV_Q);
        case (est_reg.sector)
            hsv_pkg::SEC_RED: begin
                rgb_next.red = chan_v; rgb_next.green = chan_t; rgb_next.blue = chan_p;
            end
            hsv_pkg::SEC_YELLOW: begin
                rgb_next.red = chan_q; rgb_next.green = chan_v; rgb_next.blue = chan_p;
            end
            hsv_pkg::SEC_GREEN: begin
                rgb_next.red = chan_p; rgb_next.green = chan_v; rgb_next.blue = chan_t;
            end
            hsv_pkg::SEC_CYAN: begin
                rgb_next.red = chan_p; rgb_next.green = chan_q; rgb_next.blue = chan_v;
            end
            hsv_pkg::SEC_BLUE: begin
                rgb_next.red = chan_t; rgb_next.green = chan_p; rgb_next.blue = chan_v;
            end
            default: begin
                rgb_next.red = chan_v; rgb_next.green = chan_p; rgb_next.blue = chan_q;
            end
        endcase
    end

    assign rgb_ready = !rgb_valid_reg || out_ready;
    assign est_ready = !est_valid_reg || rgb_ready;
    assign in_ready  = est_ready;
    assign out_valid = rgb_valid_reg;
    assign out_data  = rgb_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            est_valid_reg <= 1'b0;
            rgb_valid_reg <= 1'b0;
        end else begin
            if (est_ready) begin
                est_valid_reg <= in_valid;
            end
            if (rgb_ready) begin
                rgb_valid_reg <= est_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (est_ready && in_valid) begin
            est_reg <= est_next;
        end
        if (rgb_ready && est_valid_reg) begin
            rgb_reg <= rgb_next;
        end
    end

endmodule

// File: hw/rtl/hsv_to_rgb_converter_unit.sv
// HSV to RGB color converter, top level. An accepted input item passes through the
// hsv_sector data register, then diff_reg, num_reg, est_reg and rgb_reg, to the output.
// Throughput is one item per cycle while the output is not stalled: five register stages,
// each with its own valid bit, and a stage takes a new item whenever it is
// empty or moves on. Reset (aresetn low, synchronous) clears all valid bits;
// data registers keep their contents. Depends on hsv_pkg, hsv_sector, hsv_mul and hsv_div.
module hsv_to_rgb_converter_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // hue [8:0], saturation [15:9], brightness [22:16], zero [23]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // red [7:0], green [15:8], blue [23:16]
);

    logic               sect_valid;
    logic               sect_ready;
    hsv_pkg::hsv_sect_t sect_data;
    logic               num_valid;
    logic               num_ready;
    hsv_pkg::hsv_num_t  num_data;
    hsv_pkg::hsv_rgb_t  rgb_data;

    hsv_sector u_sector (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_hue    (s_tdata[8:0]),
        .in_sat    (s_tdata[15:9]),
        .in_bri    (s_tdata[22:16]),
        .out_valid (sect_valid),
        .out_ready (sect_ready),
        .out_data  (sect_data)
    );

    hsv_mul u_mul (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (sect_valid),
        .in_ready  (sect_ready),
        .in_data   (sect_data),
        .out_valid (num_valid),
        .out_ready (num_ready),
        .out_data  (num_data)
    );

    hsv_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (num_valid),
        .in_ready  (num_ready),
        .in_data   (num_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (rgb_data)
    );

    assign m_tdata = {rgb_data.blue, rgb_data.green, rgb_data.red};

endmodule

// File: hw/rtl/hsv_checker.sv
// Port-level checks for the HSV to RGB converter, bound to its top level.
// Depends only on the top level's ports.
module hsv_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [23:0] s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);

    // Reset empties the pipeline, so no result is shown right after it.
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // A result that is not taken stays in place.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // With the output side ready while it moves through the pipeline, an accepted item is shown at the output.
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) ##1 m_tready ##1 m_tready ##1 m_tready ##1 m_tready
        |=> m_tvalid)
        else $error("result missing five cycles after an accepted item");

    // Zero brightness gives black, whatever hue and saturation are.
    a_black: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tdata[22:16] == 7'd0)
        ##1 m_tready ##1 m_tready ##1 m_tready ##1 m_tready
        |=> m_tvalid && m_tdata == 24'd0)
        else $error("zero brightness did not give black");

endmodule

bind hsv_to_rgb_converter_unit hsv_checker u_hsv_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// File: verif/hsv_rgb_checker.sv
// Checker for the HSV to RGB converter: watches both stream channels, predicts
// the color of every accepted input item and compares it with the result.
// Depends on hsv_pkg for the result layout and the sector codes.
module hsv_rgb_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,   // hue [8:0], saturation [15:9], brightness [22:16], zero [23]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,   // red [7:0], green [15:8], blue [23:16]
    output int          fail_count,
    output int          pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_PRINTED = 100;

    hsv_pkg::hsv_rgb_t expected_rgb[$];
    int                errors = 0;
    int                result_idx = 0;
    int                in_flight = 0;

    assign fail_count = errors;

    // Six-sector conversion in exact integer rationals, floored.
    function automatic hsv_pkg::hsv_rgb_t rgb_from_hsv(input logic [8:0] hue_in,
                                                       input logic [6:0] sat_in,
                                                       input logic [6:0] val_in);
        int unsigned       h;
        int unsigned       s;
        int unsigned       v;
        int unsigned       frac;
        int unsigned       vv;
        int unsigned       p;
        int unsigned       q;
        int unsigned       t;
        logic [2:0]        sector;
        hsv_pkg::hsv_rgb_t rgb;
        h = hue_in;
        s = sat_in;
        v = val_in;
        if (h > 360) h = 360;
        if (s > 100) s = 100;
        if (v > 100) v = 100;
        // The hue ends are pulled one degree inward.
        if (h == 0) h = 1;
        if (h == 360) h = 359;
        sector = 3'(h / 60);
        frac = h % 60;
        vv = (255 * v) / 100;
        p  = (255 * v * (100 - s)) / 10000;
        q  = (255 * v * (6000 - frac * s)) / 600000;
        t  = (255 * v * (6000 - (60 - frac) * s)) / 600000;
        case (sector)
            hsv_pkg::SEC_RED: begin
                rgb.red = 8'(vv); rgb.green = 8'(t);  rgb.blue = 8'(p);
            end
            hsv_pkg::SEC_YELLOW: begin
                rgb.red = 8'(q);  rgb.green = 8'(vv); rgb.blue = 8'(p);
            end
            hsv_pkg::SEC_GREEN: begin
                rgb.red = 8'(p);  rgb.green = 8'(vv); rgb.blue = 8'(t);
            end
            hsv_pkg::SEC_CYAN: begin
                rgb.red = 8'(p);  rgb.green = 8'(q);  rgb.blue = 8'(vv);
            end
            hsv_pkg::SEC_BLUE: begin
                rgb.red = 8'(t);  rgb.green = 8'(p);  rgb.blue = 8'(vv);
            end
            default: begin
                rgb.red = 8'(vv); rgb.green = 8'(p);  rgb.blue = 8'(q);
            end
        endcase
        return rgb;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        if (errors < MAX_PRINTED)
            $display("checker: result %0d: %s is %0d, predicted %0d",
                     result_idx, what, got, want);
        errors++;
    endtask

    always @(posedge aclk) begin
        hsv_pkg::hsv_rgb_t got_rgb;
        hsv_pkg::hsv_rgb_t want_rgb;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got_rgb = m_tdata;
                if (expected_rgb.size() == 0) begin
                    report_mismatch("unexpected result, data", m_tdata, 0);
                end else begin
                    want_rgb = expected_rgb.pop_front();
                    in_flight--;
                    if (got_rgb.red !== want_rgb.red)
                        report_mismatch("red", got_rgb.red, want_rgb.red);
                    if (got_rgb.green !== want_rgb.green)
                        report_mismatch("green", got_rgb.green, want_rgb.green);
                    if (got_rgb.blue !== want_rgb.blue)
                        report_mismatch("blue", got_rgb.blue, want_rgb.blue);
                end
                result_idx++;
            end
            if (s_tvalid && s_tready) begin
                expected_rgb.insert(expected_rgb.size(),
                                    rgb_from_hsv(s_tdata[8:0], s_tdata[15:9],
                                                 s_tdata[22:16]));
                in_flight++;
            end
        end
        pending_count <= in_flight;
    end

endmodule

// File: verif/tb_hsv_to_rgb_converter_unit.sv
// Top of the HSV to RGB converter testbench: clock, reset, stimulus, output
// back-pressure, watchdog and verdict. Depends on the converter and hsv_rgb_checker.
module tb_hsv_to_rgb_converter_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEMS_PER_PHASE = 175;
    localparam int HOLD_CYCLES     = 200;
    localparam int HOLD_ITEMS      = 40;
    localparam int IDLE_LIMIT      = 4000;
    localparam int DRAIN_CYCLES    = 20;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;

    int fail_count;
    int pending_count;
    int send_idle  = 0;
    int recv_stall = 0;
    bit hold_off_req = 1'b0;

    hsv_to_rgb_converter_unit i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    hsv_rgb_checker i_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Output side: random stalls, or a long hold-off when one is requested.
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_stall);
            end
        end
    end

    // Ends the run when nothing moves on either channel for too long.
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    task automatic send_color(input logic [8:0] hue, input logic [6:0] sat,
                              input logic [6:0] bright);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, bright, sat, hue};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Mostly legal colors; now and then raw field bits to hit the clamps.
    task automatic send_random_color();
        if ($urandom_range(99) < 10)
            send_color(9'($urandom), 7'($urandom), 7'($urandom));
        else
            send_color(9'($urandom_range(360)), 7'($urandom_range(100)),
                       7'($urandom_range(100)));
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
    endtask

    initial begin
        logic [8:0] edge_hues[17] = '{9'd0, 9'd1, 9'd59, 9'd60, 9'd61, 9'd119, 9'd120,
                                      9'd179, 9'd180, 9'd239, 9'd240, 9'd299, 9'd300,
                                      9'd359, 9'd360, 9'd361, 9'd511};
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Sector boundaries and hue clamps, then saturation and value extremes.
        foreach (edge_hues[i])
            send_color(edge_hues[i], 7'd100, 7'd100);
        send_color(9'd180, 7'd0, 7'd100);
        send_color(9'd45, 7'd50, 7'd0);
        send_color(9'd90, 7'd127, 7'd127);
        send_color(9'd200, 7'd101, 7'd101);
        send_color(9'd330, 7'd100, 7'd1);
        send_color(9'd270, 7'd1, 7'd99);
        wait_drained();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 50; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 50; end
                default: begin send_idle = 27; recv_stall = 27; end
            endcase
            repeat (ITEMS_PER_PHASE) send_random_color();
            wait_drained();
        end

        // Long output hold-off while the sender keeps offering items.
        send_idle = 0;
        recv_stall = 0;
        hold_off_req = 1'b1;
        repeat (HOLD_ITEMS) send_random_color();
        wait_drained();

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0 && pending_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
